// ----- rtl/pwlt_pkg.sv -----
// pwlt_pkg: shared types and constants for the trajectory lookup table
// used by the interfaces, controller, datapath and top level
package pwlt_pkg;

  localparam int unsigned MaxPointsDef = 256;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned DataW        = 32;
  localparam int unsigned NumChan      = 6;

  localparam logic [1:0] OpClear  = 2'd0;
  localparam logic [1:0] OpAppend = 2'd1;
  localparam logic [1:0] OpQuery  = 2'd2;
  localparam logic [1:0] OpNop    = 2'd3;

  localparam logic [1:0] StDone  = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  // datapath commands from the controller
  typedef struct packed {
    logic capture;     // latch input beat
    logic wr_en;       // write sample at count
    logic clr_cnt;     // clear count
    logic inc_cnt;     // bump count
    logic rd_req;      // read at rd_idx
    logic ld_t0;       // load first time from read data
    logic ld_tl;       // load last time from read data
    logic ld_ta;       // load scan left time
    logic ld_tb;       // load scan right time
    logic ld_pa;       // load left point
    logic ld_pb;       // load right point
    logic div_start;   // start divider
    logic mul_step;    // one multiply step
    logic set_status;  // write result fields
    logic [1:0] res_kind;  // 0 zero, 1 left point, 2 interpolated
  } pwlt_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic [1:0] op;
    logic       empty;
    logic       full;
    logic       le_t0;
    logic       ge_tl;
    logic       in_seg;
    logic       dt_pos;
    logic       div_done;
    logic       mul_last;
  } pwlt_sts_t;

  localparam logic [1:0] ResZero   = 2'd0;
  localparam logic [1:0] ResPoint  = 2'd1;
  localparam logic [1:0] ResInterp = 2'd2;

endpackage

// ----- rtl/pwlt_in_if.sv -----
// pwlt_in_if: input beat channel (valid, ready, sample payload)
// depends on pwlt_pkg
interface pwlt_in_if import pwlt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [31:0]      sample_time;
  logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
  modport source (output valid, opcode, sample_time, pos_x, pos_y, pos_z,
                  vel_x, vel_y, vel_z, input ready);
  modport sink (input valid, opcode, sample_time, pos_x, pos_y, pos_z,
                vel_x, vel_y, vel_z, output ready);
endinterface

// ----- rtl/pwlt_out_if.sv -----
// pwlt_out_if: result beat channel (valid, ready, result payload)
// depends on pwlt_pkg
interface pwlt_out_if import pwlt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic             clamped;
  logic signed [31:0] out_x, out_y, out_z, out_vx, out_vy, out_vz;
  modport source (output valid, status, clamped, out_x, out_y, out_z,
                  out_vx, out_vy, out_vz, input ready);
  modport sink (input valid, status, clamped, out_x, out_y, out_z,
                out_vx, out_vy, out_vz, output ready);
endinterface

// ----- rtl/pwlt_ram.sv -----
// pwlt_ram: generic single-port RAM with registered read
// no dependencies
module pwlt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end
endmodule

// ----- rtl/pwlt_dp.sv -----
// pwlt_dp: sample storage, scan compares, serial divider, serial multiplier
// depends on pwlt_pkg and pwlt_ram
module pwlt_dp import pwlt_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDef,
  parameter int unsigned FracBits  = FracBitsDef,
  localparam int unsigned AddrW    = $clog2(MaxPoints),
  localparam int unsigned CntW     = $clog2(MaxPoints + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pwlt_cmd_t      cmd_i,
  input  logic [AddrW-1:0] rd_idx_i,
  output pwlt_sts_t      sts_o,
  output logic [CntW-1:0] count_o,
  pwlt_in_if.sink        in_if,
  output logic [1:0]     status_o,
  output logic           clamped_o,
  output logic [NumChan*DataW-1:0] res_o
);
  localparam int unsigned QW = 32 + FracBits;   // divider quotient width
  localparam int unsigned AW = 31;              // alpha width after clamp
  localparam int unsigned DW = 33;              // channel difference width
  localparam int unsigned PW = AW + DW;         // product width

  logic [CntW-1:0] cnt_q;
  logic [1:0]  op_q;
  logic [31:0] t_q;
  logic [NumChan*DataW-1:0] smp_q;
  logic [31:0] t0_q, tl_q, ta_q, tb_q;
  logic [NumChan*DataW-1:0] pa_q, pb_q;
  logic [31:0] rd_time;
  logic [NumChan*DataW-1:0] rd_pt;
  logic [AddrW-1:0] addr;
  logic wr;

  // count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.clr_cnt) begin
      cnt_q <= '0;
    end else if (cmd_i.inc_cnt) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end
  assign count_o = cnt_q;

  // capture the input beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_if.opcode;
      t_q   <= in_if.sample_time;
      smp_q <= {in_if.vel_z, in_if.vel_y, in_if.vel_x,
                in_if.pos_z, in_if.pos_y, in_if.pos_x};
    end
  end

  // storage: one RAM for time, one per channel
  assign wr   = cmd_i.wr_en;
  assign addr = wr ? cnt_q[AddrW-1:0] : rd_idx_i;

  pwlt_ram #(.Width(DataW), .Depth(MaxPoints)) u_time (
    .clk_i, .we_i(wr), .re_i(cmd_i.rd_req), .addr_i(addr), .wdata_i(t_q),
    .rdata_o(rd_time));

  for (genvar c = 0; c < NumChan; c++) begin : g_chan
    pwlt_ram #(.Width(DataW), .Depth(MaxPoints)) u_chan (
      .clk_i, .we_i(wr), .re_i(cmd_i.rd_req), .addr_i(addr),
      .wdata_i(smp_q[c*DataW +: DataW]), .rdata_o(rd_pt[c*DataW +: DataW]));
  end

  // scan registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_t0) t0_q <= rd_time;
    if (cmd_i.ld_tl) tl_q <= rd_time;
    if (cmd_i.ld_ta) ta_q <= rd_time;
    if (cmd_i.ld_tb) tb_q <= rd_time;
    if (cmd_i.ld_pa) pa_q <= rd_pt;
    if (cmd_i.ld_pb) pb_q <= rd_pt;
  end

  // serial restoring divider: (t - ta) << FracBits / (tb - ta)
  logic [QW-1:0] quo_q, num_q;
  logic [32:0]   rem_q;
  logic [31:0]   den_q;
  logic [$clog2(QW+1)-1:0] dcnt_q;
  logic          dbusy_q;
  logic [32:0]   rem_sh;
  always_comb rem_sh = {rem_q[31:0], num_q[QW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= '0;
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q + 1'b1;
      if (dcnt_q == ($clog2(QW+1))'(QW - 1)) dbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q <= QW'({(t_q - ta_q), FracBits'(0)});
      den_q <= tb_q - ta_q;
      rem_q <= '0;
      quo_q <= '0;
    end else if (dbusy_q) begin
      num_q <= {num_q[QW-2:0], 1'b0};
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
    end
  end

  // alpha saturated at 2^30
  logic [AW-1:0] alpha;
  always_comb begin
    if (quo_q > QW'(32'h4000_0000)) alpha = AW'(32'h4000_0000);
    else alpha = quo_q[AW-1:0];
  end

  // serial shift-add multiplier, one channel at a time
  logic [2:0]  ch_q;
  logic [$clog2(AW+1)-1:0] mcnt_q;
  logic signed [PW-1:0] acc_q;
  logic signed [PW-1:0] diff_ext;
  logic signed [DW-1:0] diff;
  logic signed [31:0] pa_c, pb_c;
  logic [NumChan*DataW-1:0] lerp_q;
  logic signed [PW-1:0] fl;
  logic signed [PW-1:0] r;
  logic signed [31:0] sat;

  always_comb begin
    pa_c = pa_q[ch_q*DataW +: DataW];
    pb_c = pb_q[ch_q*DataW +: DataW];
    diff = DW'(pb_c) - DW'(pa_c);
    diff_ext = PW'(diff);
    fl = acc_q >>> FracBits;
    r  = fl + PW'(pa_c);
    if (r > PW'(64'sh7FFF_FFFF)) sat = 32'sh7FFF_FFFF;
    else if (r < -PW'(64'sh8000_0000)) sat = 32'sh8000_0000;
    else sat = r[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q   <= '0;
      mcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      ch_q   <= '0;
      mcnt_q <= '0;
    end else if (cmd_i.mul_step) begin
      if (mcnt_q == ($clog2(AW+1))'(AW)) begin
        mcnt_q <= '0;
        ch_q   <= ch_q + 3'd1;
      end else begin
        mcnt_q <= mcnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      acc_q <= '0;
    end else if (cmd_i.mul_step) begin
      if (mcnt_q == ($clog2(AW+1))'(AW)) begin
        lerp_q[ch_q*DataW +: DataW] <= sat;
        acc_q <= '0;
      end else if (alpha[mcnt_q[$clog2(AW)-1:0]]) begin
        acc_q <= acc_q + (diff_ext <<< mcnt_q);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_status) begin
      unique case (cmd_i.res_kind)
        ResPoint:  res_o <= pa_q;
        ResInterp: res_o <= lerp_q;
        default:   res_o <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_status) begin
      if (op_q == OpAppend && cnt_q == CntW'(MaxPoints)) status_o <= StFull;
      else if (op_q == OpQuery && cnt_q == '0) status_o <= StEmpty;
      else status_o <= StDone;
      clamped_o <= (op_q == OpQuery) && (cnt_q != '0) &&
                   (t_q <= t0_q || t_q >= tl_q);
    end
  end

  // status to controller
  always_comb begin
    sts_o.op       = op_q;
    sts_o.empty    = (cnt_q == '0);
    sts_o.full     = (cnt_q == CntW'(MaxPoints));
    sts_o.le_t0    = t_q <= t0_q;
    sts_o.ge_tl    = t_q >= tl_q;
    sts_o.in_seg   = (rd_time > t_q) && (ta_q <= t_q);
    sts_o.dt_pos   = tb_q > ta_q;
    sts_o.div_done = !dbusy_q && !cmd_i.div_start;
    sts_o.mul_last = (ch_q == 3'(NumChan - 1)) && (mcnt_q == ($clog2(AW+1))'(AW));
  end
endmodule

// ----- rtl/pwlt_ctrl.sv -----
// pwlt_ctrl: sequencer for clear, append and query beats
// depends on pwlt_pkg
module pwlt_ctrl import pwlt_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDef,
  localparam int unsigned AddrW    = $clog2(MaxPoints),
  localparam int unsigned CntW     = $clog2(MaxPoints + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  pwlt_sts_t       sts_i,
  input  logic [CntW-1:0] count_i,
  output pwlt_cmd_t       cmd_o,
  output logic [AddrW-1:0] rd_idx_o
);
  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SDec   = 4'd1;
  localparam logic [3:0] SRd0   = 4'd2;
  localparam logic [3:0] SRdL   = 4'd3;
  localparam logic [3:0] SEnds  = 4'd4;
  localparam logic [3:0] SScanA = 4'd5;
  localparam logic [3:0] SScanB = 4'd6;
  localparam logic [3:0] SChk   = 4'd7;
  localparam logic [3:0] SFb    = 4'd8;
  localparam logic [3:0] SFbB   = 4'd9;
  localparam logic [3:0] SDiv   = 4'd10;
  localparam logic [3:0] SMul   = 4'd11;
  localparam logic [3:0] SRes   = 4'd12;
  localparam logic [3:0] SOut   = 4'd13;
  localparam logic [3:0] SWait  = 4'd14;
  localparam logic [3:0] SSeg   = 4'd15;

  logic [3:0] st_q, st_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [1:0] kind_q, kind_d;
  logic [AddrW-1:0] last;

  assign last = AddrW'(count_i - CntW'(1));
  assign in_ready_o  = (st_q == SIdle);
  assign out_valid_o = (st_q == SOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SIdle;
      idx_q  <= '0;
      kind_q <= ResZero;
    end else begin
      st_q   <= st_d;
      idx_q  <= idx_d;
      kind_q <= kind_d;
    end
  end

  // next state and commands
  always_comb begin
    st_d = st_q;
    idx_d = idx_q;
    kind_d = kind_q;
    cmd_o = '0;
    cmd_o.res_kind = kind_q;
    rd_idx_o = idx_q;
    unique case (st_q)
      SIdle: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) st_d = SDec;
      end
      SDec: begin
        kind_d = ResZero;
        unique case (sts_i.op)
          OpClear:  begin cmd_o.clr_cnt = 1'b1; st_d = SRes; end
          OpAppend: begin
            if (!sts_i.full) begin
              cmd_o.wr_en = 1'b1;
            end
            st_d = SWait;
          end
          OpQuery: begin
            if (sts_i.empty) st_d = SRes;
            else begin
              rd_idx_o = '0; cmd_o.rd_req = 1'b1; st_d = SRd0;
            end
          end
          default: st_d = SRes;
        endcase
      end
      SWait: begin
        // count bump after the write
        cmd_o.set_status = 1'b1;
        if (!sts_i.full) cmd_o.inc_cnt = 1'b1;
        st_d = SOut;
      end
      SRd0: begin
        cmd_o.ld_t0 = 1'b1; cmd_o.ld_ta = 1'b1; cmd_o.ld_pa = 1'b1;
        rd_idx_o = last; cmd_o.rd_req = 1'b1;
        st_d = SRdL;
      end
      SRdL: begin
        cmd_o.ld_tl = 1'b1; cmd_o.ld_pb = 1'b1;
        st_d = SEnds;
      end
      SEnds: begin
        if (sts_i.le_t0) begin
          kind_d = ResPoint; st_d = SRes;
        end else if (sts_i.ge_tl) begin
          // last point: move it to the left register
          rd_idx_o = last; cmd_o.rd_req = 1'b1;
          kind_d = ResPoint; idx_d = last; st_d = SFbB;
        end else begin
          idx_d = '0; rd_idx_o = AddrW'(1); cmd_o.rd_req = 1'b1;
          st_d = SScanB;
        end
      end
      SScanA: begin
        // read left of candidate idx
        rd_idx_o = idx_q; cmd_o.rd_req = 1'b1; st_d = SChk;
      end
      SChk: begin
        cmd_o.ld_ta = 1'b1;
        rd_idx_o = idx_q + AddrW'(1); cmd_o.rd_req = 1'b1;
        st_d = SScanB;
      end
      SScanB: begin
        if (sts_i.in_seg) begin
          cmd_o.ld_tb = 1'b1; cmd_o.ld_pb = 1'b1;
          rd_idx_o = idx_q; cmd_o.rd_req = 1'b1;
          st_d = SSeg; kind_d = ResInterp;
        end else if (idx_q + AddrW'(1) >= last) begin
          idx_d = '0; rd_idx_o = '0; cmd_o.rd_req = 1'b1; st_d = SFb;
          kind_d = ResInterp;
        end else begin
          idx_d = idx_q + AddrW'(1); st_d = SScanA;
        end
      end
      SSeg: begin
        // left point of the found segment
        cmd_o.ld_pa = 1'b1; st_d = SDiv;
      end
      SFb: begin
        cmd_o.ld_ta = 1'b1; cmd_o.ld_pa = 1'b1;
        rd_idx_o = AddrW'(1); cmd_o.rd_req = 1'b1;
        st_d = SFbB; idx_d = '0;
      end
      SFbB: begin
        if (kind_q == ResPoint) begin
          cmd_o.ld_pa = 1'b1; st_d = SRes;
        end else begin
          // right point of the fallback segment
          cmd_o.ld_tb = 1'b1; cmd_o.ld_pb = 1'b1;
          st_d = SDiv;
        end
      end
      SDiv: begin
        if (!sts_i.dt_pos) begin
          kind_d = ResPoint; st_d = SRes;
        end else begin
          cmd_o.div_start = 1'b1; st_d = SMul;
        end
      end
      SMul: begin
        if (sts_i.div_done) begin
          cmd_o.mul_step = 1'b1;
          if (sts_i.mul_last) st_d = SRes;
        end
      end
      SRes: begin
        cmd_o.set_status = 1'b1; st_d = SOut;
      end
      SOut: begin
        if (out_ready_i) st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  // only one of in_ready and out_valid at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && out_valid_o))
    else $error("ready and valid overlap");
  // result follows its setup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.set_status |=> out_valid_o) else $error("result not shown");
  // no writes outside decode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> (st_q == SDec)) else $error("stray write");
endmodule

// ----- rtl/piecewise_linear_trajectory_lookup_top.sv -----
// piecewise_linear_trajectory_lookup_top: sample table with linear lookup
// depends on pwlt_pkg, pwlt_in_if, pwlt_out_if, pwlt_ctrl, pwlt_dp
// one beat at a time: clear, append and no-op pass through the decode state and a result
// state before the result is shown, and a new beat is taken only after the result is accepted
// a query scans one segment at a time through SScanA, SChk and SScanB on the shared RAM
// read port, then runs a 48-step serial divide (default FracBits) and 6 serial 32-step multiplies
// reset clears the sample count; table contents are not cleared and keep whatever they held
module piecewise_linear_trajectory_lookup_top import pwlt_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDef,
  parameter int unsigned FracBits  = FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pwlt_in_if.sink     in_if,
  pwlt_out_if.source  out_if
);
  localparam int unsigned AddrW = $clog2(MaxPoints);
  localparam int unsigned CntW  = $clog2(MaxPoints + 1);

  pwlt_cmd_t cmd;
  pwlt_sts_t sts;
  logic [CntW-1:0] count;
  logic [AddrW-1:0] rd_idx;
  logic [NumChan*DataW-1:0] res;

  pwlt_ctrl #(.MaxPoints(MaxPoints)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .sts_i(sts),
    .count_i(count), .cmd_o(cmd), .rd_idx_o(rd_idx));

  pwlt_dp #(.MaxPoints(MaxPoints), .FracBits(FracBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .rd_idx_i(rd_idx), .sts_o(sts),
    .count_o(count), .in_if(in_if), .status_o(out_if.status),
    .clamped_o(out_if.clamped), .res_o(res));

  assign out_if.out_x  = res[0*DataW +: DataW];
  assign out_if.out_y  = res[1*DataW +: DataW];
  assign out_if.out_z  = res[2*DataW +: DataW];
  assign out_if.out_vx = res[3*DataW +: DataW];
  assign out_if.out_vy = res[4*DataW +: DataW];
  assign out_if.out_vz = res[5*DataW +: DataW];
endmodule
